### hw/rtl/limit_order_matching_engine_macros.svh
// Assertion macros used by the matching engine module.
`ifndef LIMIT_ORDER_MATCHING_ENGINE_MACROS_SVH
`define LIMIT_ORDER_MATCHING_ENGINE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LOME_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LOME_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/lome_pkg.sv
// Types, constants and helper functions of the limit order matching engine.
package lome_pkg;

    localparam int BOOK_DEPTH = 32;
    localparam int AW = $clog2(BOOK_DEPTH);
    localparam int CW = $clog2(BOOK_DEPTH + 1);
    localparam int QUEUE_DEPTH = 2;

    // Command codes.
    localparam logic [1:0] CMD_ENTER_BUY = 2'd0;
    localparam logic [1:0] CMD_ENTER_SELL = 2'd1;
    localparam logic [1:0] CMD_SHOW_BUY = 2'd2;
    localparam logic [1:0] CMD_SHOW_SELL = 2'd3;

    // Result kinds.
    localparam logic [2:0] KIND_TRADE = 3'd0;
    localparam logic [2:0] KIND_TOP = 3'd1;
    localparam logic [2:0] KIND_EMPTY = 3'd2;
    localparam logic [2:0] KIND_ACCEPTED = 3'd3;
    localparam logic [2:0] KIND_FULL = 3'd4;

    // Book sides.
    localparam logic SIDE_BUY = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    typedef struct packed {
        logic [1:0]  command;
        logic [17:0] order_time;
        logic [15:0] trader_id;
        logic [23:0] price_cents;
        logic [19:0] quantity;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [23:0] trade_price;
        logic [19:0] trade_quantity;
        logic [15:0] buyer_id;
        logic [19:0] buyer_left;
        logic [15:0] seller_id;
        logic [19:0] seller_left;
        logic [15:0] top_trader;
        logic [17:0] top_time;
        logic [23:0] top_price;
        logic [19:0] top_quantity;
        logic        last;
    } t_out_item;

    // One order as stored in a book.
    typedef struct packed {
        logic [23:0] price;
        logic [17:0] otime;
        logic [19:0] qty;
        logic [15:0] trader;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Classified word passed from the front to the engine.
    typedef struct packed {
        logic   is_show;
        logic   side;
        t_entry entry;
    } t_job;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DISPATCH, ST_UP_CMP, ST_UP_FIN, ST_TOPS, ST_CHK, ST_TRADE,
        ST_RM_NEXT, ST_RM_LD, ST_DN_CMP, ST_SHOW, ST_EMITL
    } t_state;

    // True if order a ranks strictly before order b in the given book.
    function automatic logic better(input t_entry a, input t_entry b, input logic side);
        logic res;
        if (a.price != b.price) begin
            res = (side == SIDE_BUY) ? (a.price > b.price) : (a.price < b.price);
        end else begin
            res = a.otime < b.otime;
        end
        return res;
    endfunction

endpackage

### hw/rtl/lome_ram.sv
// Generic RAM with one write port and two registered read ports.
module lome_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read ports hold their data until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

### hw/rtl/lome_front.sv
// Front end: accepts input words, classifies them and queues them for the engine.
module lome_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  lome_pkg::t_in_item i_in_data,
    output logic              o_job_valid,
    input  logic              i_job_pop,
    output lome_pkg::t_job    o_job
);

    lome_pkg::t_job r_q [lome_pkg::QUEUE_DEPTH];
    logic [$clog2(lome_pkg::QUEUE_DEPTH)-1:0] r_wptr;
    logic [$clog2(lome_pkg::QUEUE_DEPTH)-1:0] r_rptr;
    logic [$clog2(lome_pkg::QUEUE_DEPTH+1)-1:0] r_cnt;
    lome_pkg::t_job n_job;
    logic push;
    logic pop;

    // Classify the command into a side and an operation.
    always_comb begin
        n_job.is_show = (i_in_data.command == lome_pkg::CMD_SHOW_BUY) ||
                        (i_in_data.command == lome_pkg::CMD_SHOW_SELL);
        n_job.side = (i_in_data.command == lome_pkg::CMD_ENTER_SELL) ||
                     (i_in_data.command == lome_pkg::CMD_SHOW_SELL);
        n_job.entry.price = i_in_data.price_cents;
        n_job.entry.otime = i_in_data.order_time;
        n_job.entry.qty = i_in_data.quantity;
        n_job.entry.trader = i_in_data.trader_id;
    end

    assign o_in_ready = (r_cnt != ($bits(r_cnt))'(lome_pkg::QUEUE_DEPTH));
    assign push = i_in_valid && o_in_ready;
    assign o_job_valid = (r_cnt != '0);
    assign pop = i_job_pop && o_job_valid;
    assign o_job = r_q[r_rptr];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= n_job;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

### hw/rtl/lome_engine.sv
// Back end: keeps both heaps in RAM, sifts orders, matches and emits result words.
`include "limit_order_matching_engine_macros.svh"

module lome_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    output logic                o_job_pop,
    input  lome_pkg::t_job      i_job,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lome_pkg::t_out_item o_out_data
);

    localparam int AW = lome_pkg::AW;
    localparam int CW = lome_pkg::CW;

    lome_pkg::t_state r_state, n_state;
    lome_pkg::t_job r_job, n_job;
    lome_pkg::t_entry r_x, n_x;
    logic [AW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_count [2];
    logic [CW-1:0] n_count [2];
    logic [CW-1:0] r_k, n_k;
    logic r_side, n_side;
    logic [1:0] r_rm, n_rm;
    lome_pkg::t_out_item r_pend, n_pend;
    logic r_out_valid;
    lome_pkg::t_out_item r_out;
    lome_pkg::t_out_item n_out;
    logic emit;
    logic out_free;

    // RAM ports, one set per book.
    logic we [2];
    logic [AW-1:0] waddr [2];
    lome_pkg::t_entry wdata [2];
    logic re [2];
    logic [AW-1:0] ra [2];
    logic [AW-1:0] rb [2];
    logic [lome_pkg::ENTRY_W-1:0] rda_raw [2];
    logic [lome_pkg::ENTRY_W-1:0] rdb_raw [2];
    lome_pkg::t_entry rda [2];
    lome_pkg::t_entry rdb [2];

    for (genvar g = 0; g < 2; g++) begin : g_book
        lome_ram #(
            .WIDTH(lome_pkg::ENTRY_W),
            .DEPTH(lome_pkg::BOOK_DEPTH)
        ) u_ram (
            .i_clk(i_clk),
            .i_we(we[g]),
            .i_waddr(waddr[g]),
            .i_wdata(wdata[g]),
            .i_re(re[g]),
            .i_raddr_a(ra[g]),
            .i_raddr_b(rb[g]),
            .o_rdata_a(rda_raw[g]),
            .o_rdata_b(rdb_raw[g])
        );
        assign rda[g] = lome_pkg::t_entry'(rda_raw[g]);
        assign rdb[g] = lome_pkg::t_entry'(rdb_raw[g]);
    end

    assign out_free = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out;

    // Index arithmetic for the heap walk, plus the cross test and the trade figures.
    logic [CW:0] lchild;
    logic [CW:0] rchild;
    logic [AW-1:0] parent;
    logic [AW-1:0] choice;
    logic [CW:0] next_lchild;
    logic [CW:0] next_rchild;
    lome_pkg::t_entry cent;
    logic books_cross;
    logic [19:0] tq;
    logic [24:0] psum;

    always_comb begin
        lchild = {1'b0, r_idx, 1'b1};
        rchild = lchild + 1'b1;
        parent = (r_idx - 1'b1) >> 1;
        if ((rchild < ($bits(rchild))'(r_count[r_side])) &&
            lome_pkg::better(rdb[r_side], rda[r_side], r_side)) begin
            choice = rchild[AW-1:0];
            cent = rdb[r_side];
        end else begin
            choice = lchild[AW-1:0];
            cent = rda[r_side];
        end
        next_lchild = {1'b0, choice, 1'b1};
        next_rchild = next_lchild + 1'b1;
        books_cross = (r_count[0] != '0) && (r_count[1] != '0) &&
                      (rda[1].price <= rda[0].price) &&
                      (r_k < ($bits(r_k))'(lome_pkg::BOOK_DEPTH));
        tq = (rda[1].qty < rda[0].qty) ? rda[1].qty : rda[0].qty;
        psum = {1'b0, rda[0].price} + {1'b0, rda[1].price};
    end

    // Sequencer: next state, RAM controls and result words.
    always_comb begin
        n_state = r_state;
        n_job = r_job;
        n_x = r_x;
        n_idx = r_idx;
        n_count = r_count;
        n_k = r_k;
        n_side = r_side;
        n_rm = r_rm;
        n_pend = r_pend;
        n_out = r_pend;
        emit = 1'b0;
        o_job_pop = 1'b0;
        for (int b = 0; b < 2; b++) begin
            we[b] = 1'b0;
            waddr[b] = r_idx;
            wdata[b] = r_x;
            re[b] = 1'b0;
            ra[b] = '0;
            rb[b] = '0;
        end
        case (r_state)
            lome_pkg::ST_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_job = i_job;
                    n_side = i_job.side;
                    n_state = lome_pkg::ST_DISPATCH;
                end
            end
            lome_pkg::ST_DISPATCH: begin
                n_pend = '0;
                if (r_job.is_show) begin
                    re[r_side] = 1'b1;
                    n_state = lome_pkg::ST_SHOW;
                end else if (r_count[r_side] >= ($bits(r_count[0]))'(lome_pkg::BOOK_DEPTH)) begin
                    n_pend.result_kind = lome_pkg::KIND_FULL;
                    n_state = lome_pkg::ST_EMITL;
                end else begin
                    n_x = r_job.entry;
                    n_count[r_side] = r_count[r_side] + 1'b1;
                    n_idx = r_count[r_side][AW-1:0];
                    if (r_count[r_side] == '0) begin
                        n_state = lome_pkg::ST_UP_FIN;
                    end else begin
                        re[r_side] = 1'b1;
                        ra[r_side] = (r_count[r_side][AW-1:0] - 1'b1) >> 1;
                        n_state = lome_pkg::ST_UP_CMP;
                    end
                end
            end
            lome_pkg::ST_UP_CMP: begin
                we[r_side] = 1'b1;
                if (lome_pkg::better(r_x, rda[r_side], r_side)) begin
                    wdata[r_side] = rda[r_side];
                    n_idx = parent;
                    if (parent == '0) begin
                        n_state = lome_pkg::ST_UP_FIN;
                    end else begin
                        re[r_side] = 1'b1;
                        ra[r_side] = (parent - 1'b1) >> 1;
                    end
                end else begin
                    n_pend.result_kind = lome_pkg::KIND_ACCEPTED;
                    n_k = '0;
                    n_state = lome_pkg::ST_TOPS;
                end
            end
            lome_pkg::ST_UP_FIN: begin
                we[r_side] = 1'b1;
                n_pend.result_kind = lome_pkg::KIND_ACCEPTED;
                n_k = '0;
                n_state = lome_pkg::ST_TOPS;
            end
            lome_pkg::ST_TOPS: begin
                re[0] = 1'b1;
                re[1] = 1'b1;
                n_state = lome_pkg::ST_CHK;
            end
            lome_pkg::ST_CHK: begin
                if (out_free) begin
                    emit = 1'b1;
                    n_out.last = !books_cross;
                    n_state = books_cross ? lome_pkg::ST_TRADE : lome_pkg::ST_IDLE;
                end
            end
            lome_pkg::ST_TRADE: begin
                n_pend = '0;
                n_pend.result_kind = lome_pkg::KIND_TRADE;
                n_pend.trade_price = psum[24:1];
                n_pend.trade_quantity = tq;
                n_pend.buyer_id = rda[0].trader;
                n_pend.buyer_left = rda[0].qty - tq;
                n_pend.seller_id = rda[1].trader;
                n_pend.seller_left = rda[1].qty - tq;
                for (int b = 0; b < 2; b++) begin
                    we[b] = 1'b1;
                    waddr[b] = '0;
                    wdata[b] = rda[b];
                    wdata[b].qty = rda[b].qty - tq;
                end
                n_rm = {rda[1].qty == tq, rda[0].qty == tq};
                n_k = r_k + 1'b1;
                n_state = lome_pkg::ST_RM_NEXT;
            end
            lome_pkg::ST_RM_NEXT: begin
                if (r_rm[0] || r_rm[1]) begin
                    n_side = r_rm[0] ? lome_pkg::SIDE_BUY : lome_pkg::SIDE_SELL;
                    if (r_rm[0]) begin
                        n_rm[0] = 1'b0;
                    end else begin
                        n_rm[1] = 1'b0;
                    end
                    n_count[n_side] = r_count[n_side] - 1'b1;
                    if (r_count[n_side] != ($bits(r_count[0]))'(1)) begin
                        re[n_side] = 1'b1;
                        ra[n_side] = n_count[n_side][AW-1:0];
                        n_state = lome_pkg::ST_RM_LD;
                    end
                end else begin
                    n_state = lome_pkg::ST_TOPS;
                end
            end
            lome_pkg::ST_RM_LD: begin
                n_x = rda[r_side];
                n_idx = '0;
                re[r_side] = 1'b1;
                ra[r_side] = ($bits(ra[0]))'(1);
                rb[r_side] = ($bits(rb[0]))'(2);
                n_state = lome_pkg::ST_DN_CMP;
            end
            lome_pkg::ST_DN_CMP: begin
                we[r_side] = 1'b1;
                if ((lchild < ($bits(lchild))'(r_count[r_side])) &&
                    lome_pkg::better(cent, r_x, r_side)) begin
                    wdata[r_side] = cent;
                    n_idx = choice;
                    re[r_side] = 1'b1;
                    ra[r_side] = next_lchild[AW-1:0];
                    rb[r_side] = next_rchild[AW-1:0];
                end else begin
                    n_state = lome_pkg::ST_RM_NEXT;
                end
            end
            lome_pkg::ST_SHOW: begin
                if (r_count[r_side] == '0) begin
                    n_pend.result_kind = lome_pkg::KIND_EMPTY;
                end else begin
                    n_pend.result_kind = lome_pkg::KIND_TOP;
                    n_pend.top_trader = rda[r_side].trader;
                    n_pend.top_time = rda[r_side].otime;
                    n_pend.top_price = rda[r_side].price;
                    n_pend.top_quantity = rda[r_side].qty;
                end
                n_state = lome_pkg::ST_EMITL;
            end
            lome_pkg::ST_EMITL: begin
                if (out_free) begin
                    emit = 1'b1;
                    n_out.last = 1'b1;
                    n_state = lome_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lome_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lome_pkg::ST_IDLE;
            r_count[0] <= '0;
            r_count[1] <= '0;
            r_out_valid <= 1'b0;
            r_rm <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_rm <= n_rm;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        r_x <= n_x;
        r_idx <= n_idx;
        r_k <= n_k;
        r_side <= n_side;
        r_pend <= n_pend;
        if (emit) begin
            r_out <= n_out;
        end
    end

    `LOME_ASSERT_NOW(a_buy_bound, 1'b1, r_count[0] <= CW'(lome_pkg::BOOK_DEPTH), "buy count over depth")
    `LOME_ASSERT_NOW(a_sell_bound, 1'b1, r_count[1] <= CW'(lome_pkg::BOOK_DEPTH), "sell count over depth")
    `LOME_ASSERT_NOW(a_trade_books, r_state == lome_pkg::ST_TRADE, (r_count[0] != '0) && (r_count[1] != '0), "trade with an empty book")
    `LOME_ASSERT_NEXT(a_emit_valid, emit, o_out_valid, "emitted word not shown")

endmodule

### hw/rtl/limit_order_matching_engine.sv
// A show reads the top of its book and emits one word; an entered order sifts up its heap unless the book is full.
// Each trade rewrites both book tops, and each order filled is removed by a sift down its heap.
// One word is in the engine at a time; the heap sift in the book RAM sets the rate.
// A two-entry queue takes new words while the engine works.
// Synchronous active-low reset empties both books and the queue; no clearing pass.
module limit_order_matching_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lome_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lome_pkg::t_out_item o_out_data
);

    logic job_valid;
    logic job_pop;
    lome_pkg::t_job job;

    // Front end: accept and classify.
    lome_front u_front (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_data(i_in_data),
        .o_job_valid(job_valid),
        .i_job_pop(job_pop),
        .o_job(job)
    );

    // Back end: books and matching.
    lome_engine u_engine (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_job_valid(job_valid),
        .o_job_pop(job_pop),
        .i_job(job),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data(o_out_data)
    );

endmodule
